// ===== sv/msh_pkg.sv =====
// Shared types and constants for the motion sensor health monitor.
package msh_pkg;

  // Failure codes reported with each result word.
  localparam logic [2:0] FAIL_NONE   = 3'd0;
  localparam logic [2:0] FAIL_DEVICE = 3'd1;
  localparam logic [2:0] FAIL_POSE   = 3'd2;
  localparam logic [2:0] FAIL_JUMP   = 3'd3;
  localparam logic [2:0] FAIL_FROZEN = 3'd4;

  // Configuration register indexes (byte address is four times the index).
  localparam int unsigned CfgAddrW = 5;
  localparam logic [2:0] REG_INVALID_CONFIRM = 3'd0;
  localparam logic [2:0] REG_JUMP_CONFIRM    = 3'd1;
  localparam logic [2:0] REG_MAX_POSE_JUMP   = 3'd2;
  localparam logic [2:0] REG_MAX_HEAD_JUMP   = 3'd3;
  localparam logic [2:0] REG_TRACK_EPSILON   = 3'd4;
  localparam logic [2:0] REG_FROZEN_DWELL    = 3'd5;
  localparam logic [2:0] REG_FROZEN_MOTOR    = 3'd6;

  // Register reset values.
  localparam logic [7:0]  RST_INVALID_CONFIRM = 8'd3;
  localparam logic [7:0]  RST_JUMP_CONFIRM    = 8'd2;
  localparam logic [22:0] RST_MAX_POSE_JUMP   = 23'd3072;
  localparam logic [45:0] RST_MAX_POSE_SQ     = 46'd9437184;
  localparam logic [13:0] RST_MAX_HEAD_JUMP   = 14'd1920;
  localparam logic [15:0] RST_TRACK_EPSILON   = 16'd64;
  localparam logic [15:0] RST_FROZEN_DWELL    = 16'd300;
  localparam logic [19:0] RST_FROZEN_MOTOR    = 20'd1440;

  // One full turn of heading in degrees Q.6.
  localparam logic signed [18:0] TURN_Q6 = 19'sd23040;

  // All six device valid bits set.
  localparam logic [5:0] DEV_ALL_VALID = 6'h3F;

  // Configuration as seen by the evaluation logic.
  typedef struct packed {
    logic [7:0]  invalid_confirm_count;
    logic [7:0]  jump_confirm_count;
    logic [45:0] max_pose_jump_sq;
    logic [13:0] max_heading_jump;
    logic [15:0] tracking_epsilon;
    logic [15:0] frozen_dwell_ms;
    logic [19:0] frozen_motor_delta;
  } msh_cfg_t;

  // One motion sample.
  typedef struct packed {
    logic               pose_usable;
    logic [5:0]         device_valid_mask;
    logic signed [23:0] pose_x;
    logic signed [23:0] pose_y;
    logic signed [15:0] heading;
    logic signed [31:0] left_track_dist;
    logic signed [31:0] right_track_dist;
    logic signed [31:0] left_motor_angle;
    logic signed [31:0] right_motor_angle;
    logic [31:0]        time_ms;
    logic               intent_idle;
  } msh_item_t;

  // Monitor state carried from sample to sample.
  typedef struct packed {
    logic               seeded;
    logic signed [23:0] prev_x;
    logic signed [23:0] prev_y;
    logic signed [15:0] prev_heading;
    logic signed [23:0] good_x;
    logic signed [23:0] good_y;
    logic signed [15:0] good_heading;
    logic signed [31:0] base_left_track;
    logic signed [31:0] base_right_track;
    logic signed [31:0] base_left_motor;
    logic signed [31:0] base_right_motor;
    logic [31:0]        left_base_time;
    logic [31:0]        right_base_time;
    logic [7:0]         bad_run;
    logic [7:0]         jump_run;
  } msh_state_t;

endpackage

// ===== sv/motion_sensor_health_monitor_core.sv =====
// Top level of the motion sensor health monitor: stream ports, staging and state.
// Each accepted sample word yields exactly one result word carrying a failure code
// and the last trusted pose. A sample enters an input register, is judged
// combinationally against the monitor state, and lands in the result register, from
// which its result word is offered; one sample is taken every cycle while the result
// register is not stalled, the limit being the state update (two 25-bit squarings, a
// sum and a compare) that each sample must finish before the next one reads the state.
// The result register frees for a new word in the same cycle that the downstream side
// takes the old one. The first sample after reset seeds the state. Write the APB
// registers only while no sample is in flight.
module motion_sensor_health_monitor_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Sample stream.
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // tdata, from bit 0: pose_x[23:0], pose_y[47:24], heading[63:48],
  // left_track_dist[95:64], right_track_dist[127:96], left_motor_angle[159:128],
  // right_motor_angle[191:160], time_ms[223:192], intent_idle[224], zeros[231:225]
  input  logic [231:0]                  s_axis_tdata,
  // tuser, from bit 0: pose_usable[0], device_valid_mask[6:1]
  input  logic [6:0]                    s_axis_tuser,
  // Result stream.
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // tdata, from bit 0: trusted_x[23:0], trusted_y[47:24], trusted_heading[63:48]
  output logic [63:0]                   m_axis_tdata,
  // tuser, from bit 0: failure_code[2:0]
  output logic [2:0]                    m_axis_tuser,
  // Configuration port.
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [msh_pkg::CfgAddrW-1:0]  paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  msh_pkg::msh_cfg_t   cfg;
  msh_pkg::msh_item_t  item_d;
  msh_pkg::msh_item_t  item_q;
  logic                item_vld_q;
  msh_pkg::msh_state_t state_q;
  msh_pkg::msh_state_t state_d;
  logic [2:0]          code_d;
  logic [2:0]          code_q;
  logic [63:0]         res_q;
  logic                res_vld_q;
  logic                res_free;
  logic                advance;
  logic                in_take;

  msh_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  msh_eval u_eval (
    .item_i  (item_q),
    .state_i (state_q),
    .cfg_i   (cfg),
    .state_o (state_d),
    .code_o  (code_d)
  );

  // Unpack the incoming word.
  assign item_d.pose_usable       = s_axis_tuser[0];
  assign item_d.device_valid_mask = s_axis_tuser[6:1];
  assign item_d.pose_x            = s_axis_tdata[23:0];
  assign item_d.pose_y            = s_axis_tdata[47:24];
  assign item_d.heading           = s_axis_tdata[63:48];
  assign item_d.left_track_dist   = s_axis_tdata[95:64];
  assign item_d.right_track_dist  = s_axis_tdata[127:96];
  assign item_d.left_motor_angle  = s_axis_tdata[159:128];
  assign item_d.right_motor_angle = s_axis_tdata[191:160];
  assign item_d.time_ms           = s_axis_tdata[223:192];
  assign item_d.intent_idle       = s_axis_tdata[224];

  // Flow control: the staged sample moves on when the result register is free
  // or is being emptied this cycle.
  assign res_free      = !res_vld_q || m_axis_tready;
  assign advance       = item_vld_q && res_free;
  assign s_axis_tready = !item_vld_q || advance;
  assign in_take       = s_axis_tvalid && s_axis_tready;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      item_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      item_q <= item_d;
    end
  end

  // Monitor state, updated once per judged sample.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_vld_q <= 1'b0;
    end else if (res_free) begin
      res_vld_q <= item_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      code_q <= code_d;
      res_q  <= {state_d.good_heading, state_d.good_y, state_d.good_x};
    end
  end

  assign m_axis_tvalid = res_vld_q;
  assign m_axis_tdata  = res_q;
  assign m_axis_tuser  = code_q;

endmodule

// ===== sv/msh_cfg_regs.sv =====
// APB configuration registers of the motion sensor health monitor.
module msh_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [msh_pkg::CfgAddrW-1:0]  paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  output msh_pkg::msh_cfg_t             cfg_o
);

  logic [7:0]  invalid_confirm_q;
  logic [7:0]  jump_confirm_q;
  logic [22:0] max_pose_jump_q;
  logic [45:0] max_pose_sq_q;
  logic [45:0] max_pose_sq_d;
  logic [13:0] max_head_jump_q;
  logic [15:0] track_epsilon_q;
  logic [15:0] frozen_dwell_q;
  logic [19:0] frozen_motor_q;
  logic [2:0]  reg_idx;
  logic        wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[msh_pkg::CfgAddrW-1:2];
  assign wr_en   = psel & penable & pwrite & pready;

  // The pose limit is kept squared so the sample path compares squares directly.
  assign max_pose_sq_d = pwdata[22:0] * pwdata[22:0];

  // Register writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      invalid_confirm_q <= msh_pkg::RST_INVALID_CONFIRM;
      jump_confirm_q    <= msh_pkg::RST_JUMP_CONFIRM;
      max_pose_jump_q   <= msh_pkg::RST_MAX_POSE_JUMP;
      max_pose_sq_q     <= msh_pkg::RST_MAX_POSE_SQ;
      max_head_jump_q   <= msh_pkg::RST_MAX_HEAD_JUMP;
      track_epsilon_q   <= msh_pkg::RST_TRACK_EPSILON;
      frozen_dwell_q    <= msh_pkg::RST_FROZEN_DWELL;
      frozen_motor_q    <= msh_pkg::RST_FROZEN_MOTOR;
    end else if (wr_en) begin
      unique case (reg_idx)
        msh_pkg::REG_INVALID_CONFIRM: invalid_confirm_q <= pwdata[7:0];
        msh_pkg::REG_JUMP_CONFIRM:    jump_confirm_q    <= pwdata[7:0];
        msh_pkg::REG_MAX_POSE_JUMP: begin
          max_pose_jump_q <= pwdata[22:0];
          max_pose_sq_q   <= max_pose_sq_d;
        end
        msh_pkg::REG_MAX_HEAD_JUMP:   max_head_jump_q   <= pwdata[13:0];
        msh_pkg::REG_TRACK_EPSILON:   track_epsilon_q   <= pwdata[15:0];
        msh_pkg::REG_FROZEN_DWELL:    frozen_dwell_q    <= pwdata[15:0];
        msh_pkg::REG_FROZEN_MOTOR:    frozen_motor_q    <= pwdata[19:0];
        default: ;
      endcase
    end
  end

  // Read back.
  always_comb begin
    unique case (reg_idx)
      msh_pkg::REG_INVALID_CONFIRM: prdata = {24'd0, invalid_confirm_q};
      msh_pkg::REG_JUMP_CONFIRM:    prdata = {24'd0, jump_confirm_q};
      msh_pkg::REG_MAX_POSE_JUMP:   prdata = {9'd0, max_pose_jump_q};
      msh_pkg::REG_MAX_HEAD_JUMP:   prdata = {18'd0, max_head_jump_q};
      msh_pkg::REG_TRACK_EPSILON:   prdata = {16'd0, track_epsilon_q};
      msh_pkg::REG_FROZEN_DWELL:    prdata = {16'd0, frozen_dwell_q};
      msh_pkg::REG_FROZEN_MOTOR:    prdata = {12'd0, frozen_motor_q};
      default:                      prdata = 32'd0;
    endcase
  end

  assign cfg_o.invalid_confirm_count = invalid_confirm_q;
  assign cfg_o.jump_confirm_count    = jump_confirm_q;
  assign cfg_o.max_pose_jump_sq      = max_pose_sq_q;
  assign cfg_o.max_heading_jump      = max_head_jump_q;
  assign cfg_o.tracking_epsilon      = track_epsilon_q;
  assign cfg_o.frozen_dwell_ms       = frozen_dwell_q;
  assign cfg_o.frozen_motor_delta    = frozen_motor_q;

endmodule

// ===== sv/msh_eval.sv =====
// Single-pass judgment of one sample: failure code and next monitor state.
module msh_eval (
  input  msh_pkg::msh_item_t  item_i,
  input  msh_pkg::msh_state_t state_i,
  input  msh_pkg::msh_cfg_t   cfg_i,
  output msh_pkg::msh_state_t state_o,
  output logic [2:0]          code_o
);

  // Magnitude of the difference of two signed 32-bit values.
  function automatic logic [32:0] abs_diff32(logic [31:0] a, logic [31:0] b);
    logic [32:0] diff;
    diff = {a[31], a} - {b[31], b};
    return diff[32] ? (~diff + 33'd1) : diff;
  endfunction

  // Magnitude of the difference of two signed 24-bit values.
  function automatic logic [24:0] abs_diff24(logic [23:0] a, logic [23:0] b);
    logic [24:0] diff;
    diff = {a[23], a} - {b[23], b};
    return diff[24] ? (~diff + 25'd1) : diff;
  endfunction

  msh_pkg::msh_state_t eff;
  logic               invalid;
  logic [7:0]         bad_inc;
  logic [7:0]         jump_inc;
  logic [24:0]        ax;
  logic [24:0]        ay;
  logic [49:0]        sqx;
  logic [49:0]        sqy;
  logic [49:0]        d2;
  logic signed [18:0] dh;
  logic signed [18:0] cand [6];
  logic [14:0]        r;
  logic [14:0]        r_rev;
  logic [14:0]        hm;
  logic               jump;
  logic               l_refresh;
  logic               r_refresh;
  logic [31:0]        l_elapsed;
  logic [31:0]        r_elapsed;
  logic               l_frozen;
  logic               r_frozen;

  // First sample seeds every piece of state from the sample itself.
  always_comb begin
    if (state_i.seeded) begin
      eff = state_i;
    end else begin
      eff.seeded           = 1'b1;
      eff.prev_x           = item_i.pose_x;
      eff.prev_y           = item_i.pose_y;
      eff.prev_heading     = item_i.heading;
      eff.good_x           = item_i.pose_x;
      eff.good_y           = item_i.pose_y;
      eff.good_heading     = item_i.heading;
      eff.base_left_track  = item_i.left_track_dist;
      eff.base_right_track = item_i.right_track_dist;
      eff.base_left_motor  = item_i.left_motor_angle;
      eff.base_right_motor = item_i.right_motor_angle;
      eff.left_base_time   = item_i.time_ms;
      eff.right_base_time  = item_i.time_ms;
      eff.bad_run          = 8'd0;
      eff.jump_run         = 8'd0;
    end
  end

  assign invalid  = !item_i.pose_usable || (item_i.device_valid_mask != msh_pkg::DEV_ALL_VALID);
  assign bad_inc  = (eff.bad_run == 8'hFF) ? eff.bad_run : eff.bad_run + 8'd1;
  assign jump_inc = (eff.jump_run == 8'hFF) ? eff.jump_run : eff.jump_run + 8'd1;

  // Squared position step.
  assign ax  = abs_diff24(item_i.pose_x, eff.prev_x);
  assign ay  = abs_diff24(item_i.pose_y, eff.prev_y);
  assign sqx = ax * ax;
  assign sqy = ay * ay;
  assign d2  = sqx + sqy;

  // Heading step into one turn: the raw step lies within three turns either way;
  // one copy shifted by -3..+2 turns is in [0, turn), none below -2 turns (r = 0).
  assign dh = 19'(item_i.heading) - 19'(eff.prev_heading);
  always_comb begin
    r = 15'd0;
    for (int k = 0; k < 6; k++) begin
      cand[k] = dh + 19'(k - 3) * msh_pkg::TURN_Q6;
    end
    for (int k = 0; k < 6; k++) begin
      if (!cand[k][18] && (cand[k] < msh_pkg::TURN_Q6)) begin
        r = cand[k][14:0];
      end
    end
  end
  assign r_rev = msh_pkg::TURN_Q6[14:0] - r;
  assign hm    = (r > r_rev) ? r_rev : r;

  assign jump = (d2 > {4'd0, cfg_i.max_pose_jump_sq}) ||
                (hm > {1'b0, cfg_i.max_heading_jump});

  // Tracker baseline refresh and frozen checks against the refreshed baselines.
  assign l_refresh = abs_diff32(item_i.left_track_dist, eff.base_left_track) >=
                     {17'd0, cfg_i.tracking_epsilon};
  assign r_refresh = abs_diff32(item_i.right_track_dist, eff.base_right_track) >=
                     {17'd0, cfg_i.tracking_epsilon};
  assign l_elapsed = item_i.time_ms - (l_refresh ? item_i.time_ms : eff.left_base_time);
  assign r_elapsed = item_i.time_ms - (r_refresh ? item_i.time_ms : eff.right_base_time);
  assign l_frozen  = (l_elapsed >= {16'd0, cfg_i.frozen_dwell_ms}) &&
                     (abs_diff32(item_i.left_motor_angle,
                                 l_refresh ? item_i.left_motor_angle : eff.base_left_motor) >=
                      {13'd0, cfg_i.frozen_motor_delta});
  assign r_frozen  = (r_elapsed >= {16'd0, cfg_i.frozen_dwell_ms}) &&
                     (abs_diff32(item_i.right_motor_angle,
                                 r_refresh ? item_i.right_motor_angle : eff.base_right_motor) >=
                      {13'd0, cfg_i.frozen_motor_delta});

  // Decision and next state.
  always_comb begin
    state_o = eff;
    code_o  = msh_pkg::FAIL_NONE;
    if (invalid) begin
      state_o.bad_run      = bad_inc;
      state_o.prev_x       = item_i.pose_x;
      state_o.prev_y       = item_i.pose_y;
      state_o.prev_heading = item_i.heading;
      if (bad_inc >= cfg_i.invalid_confirm_count) begin
        code_o = item_i.pose_usable ? msh_pkg::FAIL_DEVICE : msh_pkg::FAIL_POSE;
      end
    end else if (jump) begin
      state_o.bad_run      = 8'd0;
      state_o.jump_run     = jump_inc;
      state_o.prev_x       = item_i.pose_x;
      state_o.prev_y       = item_i.pose_y;
      state_o.prev_heading = item_i.heading;
      if (jump_inc >= cfg_i.jump_confirm_count) begin
        code_o = msh_pkg::FAIL_JUMP;
      end
    end else begin
      state_o.bad_run  = 8'd0;
      state_o.jump_run = 8'd0;
      if (item_i.intent_idle) begin
        state_o.base_left_track  = item_i.left_track_dist;
        state_o.base_right_track = item_i.right_track_dist;
        state_o.base_left_motor  = item_i.left_motor_angle;
        state_o.base_right_motor = item_i.right_motor_angle;
        state_o.left_base_time   = item_i.time_ms;
        state_o.right_base_time  = item_i.time_ms;
      end else begin
        if (l_refresh) begin
          state_o.base_left_track = item_i.left_track_dist;
          state_o.base_left_motor = item_i.left_motor_angle;
          state_o.left_base_time  = item_i.time_ms;
        end
        if (r_refresh) begin
          state_o.base_right_track = item_i.right_track_dist;
          state_o.base_right_motor = item_i.right_motor_angle;
          state_o.right_base_time  = item_i.time_ms;
        end
      end
      if (!item_i.intent_idle && (l_frozen || r_frozen)) begin
        code_o = msh_pkg::FAIL_FROZEN;
      end else begin
        state_o.prev_x       = item_i.pose_x;
        state_o.prev_y       = item_i.pose_y;
        state_o.prev_heading = item_i.heading;
        state_o.good_x       = item_i.pose_x;
        state_o.good_y       = item_i.pose_y;
        state_o.good_heading = item_i.heading;
      end
    end
  end

endmodule

// ===== bench/motion_sensor_health_monitor_core_test.sv =====
// Self-checking testbench for the motion sensor health monitor core.
module motion_sensor_health_monitor_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit = 500000;
  localparam int unsigned LongHoldCycles = 300;
  localparam int unsigned QuietTailWords = 120;
  localparam logic [2:0] REG_UNUSED = 3'd7;

  // One expected result word.
  typedef struct packed {
    logic [2:0]         code;
    logic signed [23:0] x;
    logic signed [23:0] y;
    logic signed [15:0] h;
  } verdict_t;

  // Kinds of sample runs the generator produces.
  typedef enum int {RUN_CRUISE, RUN_IDLE, RUN_INVALID, RUN_JUMP, RUN_FREEZE, RUN_NOISE} run_mode_e;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [231:0] s_axis_tdata = '0;
  logic [6:0]   s_axis_tuser = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [63:0]  m_axis_tdata;
  logic [2:0]   m_axis_tuser;
  logic         psel = 1'b0;
  logic         penable = 1'b0;
  logic         pwrite = 1'b0;
  logic [msh_pkg::CfgAddrW-1:0] paddr = '0;
  logic [31:0]  pwdata = '0;
  logic [31:0]  prdata;
  logic         pready;

  motion_sensor_health_monitor_core u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  // Sample words waiting to be sent and result words still expected.
  msh_pkg::msh_item_t sample_q[$];
  verdict_t  verdict_q[$];
  msh_pkg::msh_item_t drv_item;
  logic      in_taken = 1'b0;
  int unsigned n_in = 0;
  int unsigned mismatches = 0;
  int unsigned send_gap = 0;
  int unsigned hold_left = 0;
  bit        held_long = 1'b0;
  bit        last_phase = 1'b0;

  // Mirror of the configuration registers.
  logic [7:0]  cfg_invalid = msh_pkg::RST_INVALID_CONFIRM;
  logic [7:0]  cfg_jump    = msh_pkg::RST_JUMP_CONFIRM;
  logic [22:0] cfg_pose    = msh_pkg::RST_MAX_POSE_JUMP;
  logic [13:0] cfg_head    = msh_pkg::RST_MAX_HEAD_JUMP;
  logic [15:0] cfg_eps     = msh_pkg::RST_TRACK_EPSILON;
  logic [15:0] cfg_dwell   = msh_pkg::RST_FROZEN_DWELL;
  logic [19:0] cfg_mdel    = msh_pkg::RST_FROZEN_MOTOR;

  // Predicted monitor state.
  bit                 is_seeded = 1'b0;
  logic signed [23:0] ref_x = '0, ref_y = '0, trust_x = '0, trust_y = '0;
  logic signed [15:0] ref_h = '0, trust_h = '0;
  logic signed [31:0] lt_base = '0, rt_base = '0, lm_base = '0, rm_base = '0;
  logic [31:0]        lt_since = '0, rt_since = '0;
  logic [7:0]         bad_len = '0, jump_len = '0;

  // Simulated robot that the random runs follow.
  logic signed [23:0] w_x = '0, w_y = '0;
  logic signed [15:0] w_h = '0;
  logic signed [31:0] w_lt = '0, w_rt = '0, w_lm = '0, w_rm = '0;
  logic [31:0]        w_t = '0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic longint span(input longint a, input longint b);
    longint d;
    d = a - b;
    return (d < 0) ? -d : d;
  endfunction

  function automatic int spread(input int unsigned lim);
    return int'($urandom_range(0, 2 * lim)) - int'(lim);
  endfunction

  function automatic bit quiet_now();
    return last_phase && (sample_q.size() < QuietTailWords);
  endfunction

  // Judge one accepted sample and queue the result word it must produce.
  task automatic judge_sample(input msh_pkg::msh_item_t s);
    verdict_t    v;
    longint      dx, dy, d2, lim2, rem, hmag, turn;
    logic [31:0] el;
    logic        lf, rf;
    v.code = msh_pkg::FAIL_NONE;
    lf = 1'b0;
    rf = 1'b0;
    turn = longint'(msh_pkg::TURN_Q6);
    // The first sample after reset seeds every piece of state.
    if (!is_seeded) begin
      ref_x = s.pose_x;
      ref_y = s.pose_y;
      ref_h = s.heading;
      trust_x = s.pose_x;
      trust_y = s.pose_y;
      trust_h = s.heading;
      lt_base = s.left_track_dist;
      rt_base = s.right_track_dist;
      lm_base = s.left_motor_angle;
      rm_base = s.right_motor_angle;
      lt_since = s.time_ms;
      rt_since = s.time_ms;
      bad_len = '0;
      jump_len = '0;
      is_seeded = 1'b1;
    end
    if (!s.pose_usable || s.device_valid_mask != msh_pkg::DEV_ALL_VALID) begin
      // Invalid sample: count the run and move the jump reference.
      if (bad_len != 8'hFF) bad_len++;
      ref_x = s.pose_x;
      ref_y = s.pose_y;
      ref_h = s.heading;
      if (bad_len >= cfg_invalid) begin
        v.code = s.pose_usable ? msh_pkg::FAIL_DEVICE : msh_pkg::FAIL_POSE;
      end
    end else begin
      bad_len = '0;
      // Squared position step and wrapped heading step.
      dx = longint'(s.pose_x) - longint'(ref_x);
      dy = longint'(s.pose_y) - longint'(ref_y);
      d2 = dx * dx + dy * dy;
      lim2 = longint'(cfg_pose) * longint'(cfg_pose);
      rem = (longint'(s.heading) - longint'(ref_h)) % turn;
      if (rem < 0) rem += turn;
      hmag = (rem > turn - rem) ? turn - rem : rem;
      if (d2 > lim2 || hmag > longint'(cfg_head)) begin
        if (jump_len != 8'hFF) jump_len++;
        ref_x = s.pose_x;
        ref_y = s.pose_y;
        ref_h = s.heading;
        if (jump_len >= cfg_jump) v.code = msh_pkg::FAIL_JUMP;
      end else begin
        jump_len = '0;
        if (s.intent_idle) begin
          lt_base = s.left_track_dist;
          rt_base = s.right_track_dist;
          lm_base = s.left_motor_angle;
          rm_base = s.right_motor_angle;
          lt_since = s.time_ms;
          rt_since = s.time_ms;
        end else begin
          // A tracker that moved far enough refreshes its baseline.
          if (span(s.left_track_dist, lt_base) >= longint'(cfg_eps)) begin
            lt_base = s.left_track_dist;
            lm_base = s.left_motor_angle;
            lt_since = s.time_ms;
          end
          if (span(s.right_track_dist, rt_base) >= longint'(cfg_eps)) begin
            rt_base = s.right_track_dist;
            rm_base = s.right_motor_angle;
            rt_since = s.time_ms;
          end
          el = s.time_ms - lt_since;
          lf = (el >= 32'(cfg_dwell)) &&
               (span(s.left_motor_angle, lm_base) >= longint'(cfg_mdel));
          el = s.time_ms - rt_since;
          rf = (el >= 32'(cfg_dwell)) &&
               (span(s.right_motor_angle, rm_base) >= longint'(cfg_mdel));
        end
        if (lf || rf) begin
          v.code = msh_pkg::FAIL_FROZEN;
        end else begin
          ref_x = s.pose_x;
          ref_y = s.pose_y;
          ref_h = s.heading;
          trust_x = s.pose_x;
          trust_y = s.pose_y;
          trust_h = s.heading;
        end
      end
    end
    v.x = trust_x;
    v.y = trust_y;
    v.h = trust_h;
    verdict_q.push_back(v);
  endtask

  task automatic match_field(input string name, input longint want, input longint got);
    if (want != got) begin
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  // Check result words and predict for every accepted sample word.
  always @(posedge clk_i) begin
    verdict_t want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (verdict_q.size() == 0) begin
          $display("%0t: unexpected result word, code %0d", $time, m_axis_tuser);
          mismatches++;
        end else begin
          want = verdict_q.pop_front();
          match_field("failure_code", want.code, m_axis_tuser);
          match_field("trusted_x", want.x, $signed(m_axis_tdata[23:0]));
          match_field("trusted_y", want.y, $signed(m_axis_tdata[47:24]));
          match_field("trusted_heading", want.h, $signed(m_axis_tdata[63:48]));
        end
      end
      in_taken <= s_axis_tvalid && s_axis_tready;
      if (s_axis_tvalid && s_axis_tready) begin
        judge_sample(drv_item);
        n_in++;
      end
    end
  end

  // Sample driver with random idle bursts.
  always @(negedge clk_i) begin
    if (rst_ni && (!s_axis_tvalid || in_taken)) begin
      if (send_gap != 0) begin
        send_gap--;
        s_axis_tvalid <= 1'b0;
      end else if (sample_q.size() == 0) begin
        s_axis_tvalid <= 1'b0;
      end else if (!quiet_now() && $urandom_range(0, 9) == 0) begin
        send_gap = $urandom_range(0, 15);
        s_axis_tvalid <= 1'b0;
      end else begin
        drv_item = sample_q.pop_front();
        s_axis_tdata <= {7'd0, drv_item.intent_idle, drv_item.time_ms,
                         drv_item.right_motor_angle, drv_item.left_motor_angle,
                         drv_item.right_track_dist, drv_item.left_track_dist,
                         drv_item.heading, drv_item.pose_y, drv_item.pose_x};
        s_axis_tuser <= {drv_item.device_valid_mask, drv_item.pose_usable};
        s_axis_tvalid <= 1'b1;
      end
    end
  end

  // Result receiver: random stalls plus one long hold that backs up the block.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (hold_left != 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (!held_long && n_in >= 200) begin
        held_long = 1'b1;
        hold_left = LongHoldCycles - 1;
        m_axis_tready <= 1'b0;
      end else if (!quiet_now() && $urandom_range(0, 7) == 0) begin
        hold_left = $urandom_range(0, 15);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Register write over APB; the mirror follows once the access cycle is done.
  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    @(negedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      msh_pkg::REG_INVALID_CONFIRM: cfg_invalid = val[7:0];
      msh_pkg::REG_JUMP_CONFIRM:    cfg_jump = val[7:0];
      msh_pkg::REG_MAX_POSE_JUMP:   cfg_pose = val[22:0];
      msh_pkg::REG_MAX_HEAD_JUMP:   cfg_head = val[13:0];
      msh_pkg::REG_TRACK_EPSILON:   cfg_eps = val[15:0];
      msh_pkg::REG_FROZEN_DWELL:    cfg_dwell = val[15:0];
      msh_pkg::REG_FROZEN_MOTOR:    cfg_mdel = val[19:0];
      default: ;
    endcase
  endtask

  task automatic wait_idle();
    while (sample_q.size() != 0 || s_axis_tvalid || verdict_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic apply_settings(input int unsigned icc, input int unsigned jcc,
                                input int unsigned mpj, input int unsigned mhj,
                                input int unsigned eps, input int unsigned dwell,
                                input int unsigned mdel);
    wait_idle();
    write_reg(msh_pkg::REG_INVALID_CONFIRM, icc);
    write_reg(msh_pkg::REG_JUMP_CONFIRM, jcc);
    write_reg(msh_pkg::REG_MAX_POSE_JUMP, mpj);
    write_reg(msh_pkg::REG_MAX_HEAD_JUMP, mhj);
    write_reg(msh_pkg::REG_TRACK_EPSILON, eps);
    write_reg(msh_pkg::REG_FROZEN_DWELL, dwell);
    write_reg(msh_pkg::REG_FROZEN_MOTOR, mdel);
  endtask

  task automatic put(input bit usable, input logic [5:0] mask, input int x, input int y,
                     input int h, input int lt, input int rt, input int lm, input int rm,
                     input int unsigned t, input bit idle);
    msh_pkg::msh_item_t it;
    it.pose_usable = usable;
    it.device_valid_mask = mask;
    it.pose_x = 24'(x);
    it.pose_y = 24'(y);
    it.heading = 16'(h);
    it.left_track_dist = lt;
    it.right_track_dist = rt;
    it.left_motor_angle = lm;
    it.right_motor_angle = rm;
    it.time_ms = t;
    it.intent_idle = idle;
    sample_q.push_back(it);
  endtask

  // Advance the simulated robot by one sample of the given kind and queue it.
  task automatic step_world(input run_mode_e mode, input bit freeze_l, input bit freeze_r);
    int unsigned plim, hlim;
    int          hh, d;
    bit          usable;
    logic [5:0]  mask;
    plim = (cfg_pose > 40000) ? 20000 : cfg_pose / 2;
    hlim = cfg_head / 2;
    hh = int'(w_h);
    usable = 1'b1;
    mask = msh_pkg::DEV_ALL_VALID;
    if (mode == RUN_NOISE) begin
      w_x = 24'($urandom);
      w_y = 24'($urandom);
      hh = int'($urandom_range(0, 46079)) - 23040;
      w_lt = $urandom;
      w_rt = $urandom;
      w_lm = $urandom;
      w_rm = $urandom;
      w_t = $urandom;
      usable = $urandom_range(0, 1);
      mask = 6'($urandom);
    end else begin
      // Pose and heading: a small step, or one that is too large.
      if (mode == RUN_JUMP) begin
        if (cfg_head >= 14'd11520 || $urandom_range(0, 1) == 1) begin
          d = int'(cfg_pose) + int'($urandom_range(1, 4096));
          if ($urandom_range(0, 1) == 1) w_x = w_x + 24'(d);
          else w_y = w_y - 24'(d);
        end else begin
          d = int'(cfg_head) + int'($urandom_range(1, 11520 - cfg_head));
          hh = ($urandom_range(0, 1) == 1) ? hh + d : hh - d;
        end
      end else begin
        w_x = w_x + 24'(spread(plim));
        w_y = w_y + 24'(spread(plim));
        hh = hh + spread(hlim);
      end
      // Trackers and motors; a frozen tracker stays put while its motor turns.
      if (mode == RUN_FREEZE && freeze_l) begin
        w_lm = w_lm + 32'(cfg_mdel / 3 + $urandom_range(1, 200));
      end else begin
        w_lt = w_lt + 32'(spread(2 * cfg_eps + 4));
        w_lm = w_lm + 32'(spread(600));
      end
      if (mode == RUN_FREEZE && freeze_r) begin
        w_rm = w_rm - 32'(cfg_mdel / 3 + $urandom_range(1, 200));
      end else begin
        w_rt = w_rt + 32'(spread(2 * cfg_eps + 4));
        w_rm = w_rm + 32'(spread(600));
      end
      if (mode == RUN_FREEZE) w_t = w_t + cfg_dwell / 3 + $urandom_range(1, 20);
      else w_t = w_t + $urandom_range(1, 60);
      if (mode == RUN_INVALID) begin
        usable = $urandom_range(0, 1);
        mask = usable ? 6'($urandom_range(0, 62)) : 6'($urandom);
      end
    end
    while (hh > 23039) hh -= int'(msh_pkg::TURN_Q6);
    while (hh < -23040) hh += int'(msh_pkg::TURN_Q6);
    w_h = 16'(hh);
    put(usable, mask, w_x, w_y, w_h, w_lt, w_rt, w_lm, w_rm, w_t,
        (mode == RUN_IDLE) || (mode == RUN_NOISE && $urandom_range(0, 1) == 1));
  endtask

  // Random runs: mostly plausible motion, with fault runs and noise mixed in.
  task automatic run_random(input int count);
    int        remaining, run_len, pick;
    run_mode_e mode;
    bit        freeze_l, freeze_r;
    remaining = count;
    while (remaining > 0) begin
      pick = $urandom_range(0, 99);
      if (pick < 42) mode = RUN_CRUISE;
      else if (pick < 52) mode = RUN_IDLE;
      else if (pick < 64) mode = RUN_INVALID;
      else if (pick < 76) mode = RUN_JUMP;
      else if (pick < 93) mode = RUN_FREEZE;
      else mode = RUN_NOISE;
      run_len = (mode == RUN_NOISE) ? 1 : $urandom_range(1, 6);
      freeze_l = $urandom_range(0, 1);
      freeze_r = !freeze_l || ($urandom_range(0, 1) == 1);
      for (int k = 0; k < run_len && remaining > 0; k++) begin
        step_world(mode, freeze_l, freeze_r);
        remaining--;
      end
    end
  endtask

  initial begin : stimulus
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed words under the reset configuration.
    // Seed at the extremes, then both trackers frozen across a time wrap,
    // with a heading step that wraps past a full turn.
    put(1, msh_pkg::DEV_ALL_VALID, 8388607, -8388608, 23039, 32'h7FFFFFFF, 32'h80000000,
        32'h80000000, 32'h7FFFFFFF, 32'hFFFFFF00, 1);
    put(1, msh_pkg::DEV_ALL_VALID, 8388507, -8388508, -23000, 32'h7FFFFFFF, 32'h80000000,
        32'h800007D0, 32'h7FFFF82F, 32'h40, 0);
    // An exact half turn, then position jumps across the whole range.
    put(1, msh_pkg::DEV_ALL_VALID, 8388607, -8388608, 11519, 32'h7FFFFFFF, 32'h80000000,
        32'h80000000, 32'h7FFFFFFF, 32'h50, 0);
    put(1, msh_pkg::DEV_ALL_VALID, -8388608, -8388608, 11519, 32'h7FFFFFFF, 32'h80000000,
        32'h80000000, 32'h7FFFFFFF, 32'h60, 0);
    put(1, msh_pkg::DEV_ALL_VALID, -8388608, 8388607, 11519, 32'h7FFFFFFF, 32'h80000000,
        32'h80000000, 32'h7FFFFFFF, 32'h70, 0);
    // Left tracker moves exactly epsilon; right motor stays one below the limit.
    put(1, msh_pkg::DEV_ALL_VALID, -8388508, 8388507, 11619, 32'h7FFFFFBF, 32'h8000003F,
        32'h80000010, 32'h7FFFFA60, 32'h80, 0);
    // A run of invalid samples: device flags first, then an unusable pose.
    put(1, 6'h3E, 0, 0, 0, 0, 0, 0, 0, 32'h90, 0);
    put(1, 6'h1F, 0, 0, 0, 0, 0, 0, 0, 32'hA0, 0);
    put(1, 6'h00, 0, 0, 0, 0, 0, 0, 0, 32'hB0, 0);
    put(0, msh_pkg::DEV_ALL_VALID, 0, 0, 0, 0, 0, 0, 0, 32'hC0, 0);
    // Recovery while idle, then jump limits hit exactly and just exceeded.
    put(1, msh_pkg::DEV_ALL_VALID, 0, 0, 0, 0, 0, 0, 0, 32'h100, 1);
    put(1, msh_pkg::DEV_ALL_VALID, 3072, 0, 0, 0, 0, 0, 0, 32'h110, 0);
    put(1, msh_pkg::DEV_ALL_VALID, 6144, 1, 0, 0, 0, 0, 0, 32'h120, 0);
    put(1, msh_pkg::DEV_ALL_VALID, 6144, 1, 1920, 0, 0, 0, 0, 32'h130, 0);
    put(1, msh_pkg::DEV_ALL_VALID, 6144, 1, 3841, 0, 0, 0, 0, 32'h140, 0);
    put(1, msh_pkg::DEV_ALL_VALID, 6144, 1, -23040, 0, 0, 0, 0, 32'h150, 0);
    // Frozen after exactly the dwell, then a tracker refresh clears it.
    put(1, msh_pkg::DEV_ALL_VALID, 6144, 1, -23040, 0, 0, 32'h80000000, 0, 32'h22C, 0);
    put(1, msh_pkg::DEV_ALL_VALID, 6144, 1, -23040, 32'hFFFFFFC0, 0, 32'h80000000, 0,
        32'h22D, 0);

    w_x = 24'(6144);
    w_y = 24'(1);
    w_h = 16'(-23040);
    w_t = 32'hFFFF_F000;

    // Lowest settings: every count confirms at once and every limit is zero.
    apply_settings(0, 0, 0, 0, 0, 0, 0);
    write_reg(REG_UNUSED, $urandom);
    run_random(30);

    // Highest settings.
    apply_settings(255, 255, 8388607, 11520, 65535, 65535, 1048575);
    run_random(30);

    // Long fault runs that drive both counters into saturation.
    apply_settings(255, 255, 0, 0, 64, 300, 1440);
    for (int k = 0; k < 258; k++) step_world(RUN_INVALID, 1'b0, 1'b0);
    for (int k = 0; k < 258; k++) step_world(RUN_JUMP, 1'b0, 1'b0);

    // Reset values, then moderate ones, then a random setting.
    apply_settings(3, 2, 3072, 1920, 64, 300, 1440);
    run_random(60);
    apply_settings(1, 1, 1000, 500, 32, 100, 800);
    run_random(40);
    apply_settings($urandom_range(0, 5), $urandom_range(0, 5), $urandom_range(256, 20000),
                   $urandom_range(64, 6000), $urandom_range(0, 512),
                   $urandom_range(0, 2000), $urandom_range(0, 8000));
    last_phase = 1'b1;
    run_random(60);

    wait_idle();
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Watchdog: a run that hangs counts as a failure.
  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
